// ===== design/nmea_rmc_pkg.sv =====
// Shared constants and tables for the RMC position extractor.
`default_nettype none

package nmea_rmc_pkg;

    localparam int FRAC_DIGITS_DEFAULT = 4;
    localparam int MAX_FRAC_DIGITS     = 6;
    localparam int POW10_W             = 20;  // holds 10^MAX_FRAC_DIGITS
    localparam int HDR_LEN             = 6;

    localparam logic [7:0] CHAR_DOLLAR = 8'h24;
    localparam logic [7:0] CHAR_COMMA  = 8'h2C;
    localparam logic [7:0] CHAR_STAR   = 8'h2A;
    localparam logic [7:0] CHAR_DOT    = 8'h2E;
    localparam logic [7:0] CHAR_ZERO   = 8'h30;
    localparam logic [7:0] CHAR_NINE   = 8'h39;
    localparam logic [7:0] CHAR_A      = 8'h41;
    localparam logic [7:0] CHAR_S      = 8'h53;
    localparam logic [7:0] CHAR_W      = 8'h57;

    // Field numbers counted from the first field after the header
    localparam logic [3:0] FLD_STATUS = 4'd2;
    localparam logic [3:0] FLD_LAT    = 4'd3;
    localparam logic [3:0] FLD_NS     = 4'd4;
    localparam logic [3:0] FLD_LON    = 4'd5;
    localparam logic [3:0] FLD_EW     = 4'd6;
    localparam logic [3:0] FLD_SPEED  = 4'd7;
    localparam logic [3:0] FLD_LAST   = 4'd15;

    typedef enum logic [1:0] {
        STATUS_NONE  = 2'd0,
        STATUS_A     = 2'd1,
        STATUS_OTHER = 2'd2
    } status_t;

    // Header text after '$', indexed by the number of bytes already matched minus one
    function automatic logic [7:0] hdr_char(input logic [2:0] pos);
        logic [7:0] ch;
        case (pos)
            3'd0:    ch = 8'h47;  // G
            3'd1:    ch = 8'h50;  // P
            3'd2:    ch = 8'h52;  // R
            3'd3:    ch = 8'h4D;  // M
            3'd4:    ch = 8'h43;  // C
            3'd5:    ch = 8'h2C;  // ,
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

    function automatic logic [POW10_W-1:0] pow10(input logic [2:0] n);
        logic [POW10_W-1:0] p;
        case (n)
            3'd0:    p = POW10_W'(1);
            3'd1:    p = POW10_W'(10);
            3'd2:    p = POW10_W'(100);
            3'd3:    p = POW10_W'(1000);
            3'd4:    p = POW10_W'(10000);
            3'd5:    p = POW10_W'(100000);
            3'd6:    p = POW10_W'(1000000);
            default: p = POW10_W'(1);
        endcase
        return p;
    endfunction

endpackage

`default_nettype wire

// ===== design/nmea_rmc_position_extractor_core.sv =====
// RMC sentence parser: header match, field split, fixed-point position and speed.
//
// Usage: one received character per request on the input channel (in_valid,
// in_ready, rx_byte). Each '*' that ends a "$GPRMC," sentence produces one
// request on the output channel (out_valid, out_ready) carrying the held
// latitude, longitude, the sentence's speed and fix_active. Other bytes give
// no output.
// Result: it is visible in the cycle after the '*' is accepted, from the
// output register.
// Throughput: one byte per cycle; all parsing for a byte is done in the cycle
// it is accepted, one multiply by a power of ten when a field closes.
// A byte is accepted while a result waits, as long as the output register is
// freed in the same cycle; in_ready drops only when the output register holds
// a result and out_ready is low, and then stays low until it is taken.
// Reset clears the parser state, the held position and the output valid; no
// output appears until a complete sentence has been seen.
`default_nettype none

module nmea_rmc_position_extractor_core #(
    parameter int FRAC_DIGITS = nmea_rmc_pkg::FRAC_DIGITS_DEFAULT
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire logic [7:0]          rx_byte,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output logic signed [27:0]       latitude,
    output logic signed [28:0]       longitude,
    output logic [23:0]              speed_knots,
    output logic                     fix_active
);

    localparam int FracW = $clog2(FRAC_DIGITS + 1);
    localparam longint unsigned Scale = 64'(nmea_rmc_pkg::pow10(3'(FRAC_DIGITS)));
    localparam int ScaleW = $clog2(Scale + 1);
    localparam int ProdW = 32 + ScaleW;
    localparam longint unsigned LatCap = (9060 * Scale - 1 < 64'h7FF_FFFF)
                                         ? 9060 * Scale - 1 : 64'h7FF_FFFF;
    localparam longint unsigned LonCap = (18060 * Scale - 1 < 64'hFFF_FFFF)
                                         ? 18060 * Scale - 1 : 64'hFFF_FFFF;
    localparam longint unsigned SpdCap = (1000 * Scale - 1 < 64'hFF_FFFF)
                                         ? 1000 * Scale - 1 : 64'hFF_FFFF;

    // parser state
    logic [2:0]                   header_pos_reg, header_pos_next;
    logic                         in_sentence_reg, in_sentence_next;
    logic [3:0]                   field_index_reg, field_index_next;
    logic                         field_nonempty_reg, field_nonempty_next;
    logic                         decimal_seen_reg, decimal_seen_next;
    logic                         number_stopped_reg, number_stopped_next;
    logic [FracW-1:0]             frac_count_reg, frac_count_next;
    logic [31:0]                  field_accum_reg, field_accum_next;
    nmea_rmc_pkg::status_t        status_reg, status_next;
    logic [27:0]                  lat_work_reg, lat_work_next;
    logic [28:0]                  lon_work_reg, lon_work_next;
    logic                         south_reg, south_next;
    logic                         west_reg, west_next;
    logic signed [27:0]           held_lat_reg, held_lat_next;
    logic signed [28:0]           held_lon_reg, held_lon_next;
    logic [23:0]                  held_speed_reg, held_speed_next;

    // output register
    logic                         out_valid_reg;
    logic signed [27:0]           out_lat_reg;
    logic signed [28:0]           out_lon_reg;
    logic [23:0]                  out_speed_reg;
    logic                         out_fix_reg;

    logic                         accept;
    logic                         emit;
    logic                         is_digit;
    logic                         num_field;
    logic [35:0]                  push_sum;
    logic [31:0]                  push_val;
    logic [ScaleW-1:0]            scale;
    logic [ProdW-1:0]             field_val;
    logic                         finish;

    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;

    assign is_digit  = (rx_byte >= nmea_rmc_pkg::CHAR_ZERO) &&
                       (rx_byte <= nmea_rmc_pkg::CHAR_NINE);
    assign num_field = (field_index_reg == nmea_rmc_pkg::FLD_LAT) ||
                       (field_index_reg == nmea_rmc_pkg::FLD_LON) ||
                       (field_index_reg == nmea_rmc_pkg::FLD_SPEED);

    // accum * 10 + digit, saturating at 2^32-1
    assign push_sum = {1'b0, field_accum_reg, 3'b000} + {3'b000, field_accum_reg, 1'b0}
                    + {32'd0, rx_byte[3:0]};
    assign push_val = (push_sum[35:32] != 4'd0) ? 32'hFFFF_FFFF : push_sum[31:0];

    // Only ',' and '*' close a field; neither changes the accumulator first.
    assign scale     = ScaleW'(nmea_rmc_pkg::pow10(3'(FRAC_DIGITS) - 3'(frac_count_reg)));
    assign field_val = ProdW'(field_accum_reg) * ProdW'(scale);

    always_comb
    begin
        header_pos_next     = header_pos_reg;
        in_sentence_next    = in_sentence_reg;
        field_index_next    = field_index_reg;
        field_nonempty_next = field_nonempty_reg;
        decimal_seen_next   = decimal_seen_reg;
        number_stopped_next = number_stopped_reg;
        frac_count_next     = frac_count_reg;
        field_accum_next    = field_accum_reg;
        status_next         = status_reg;
        lat_work_next       = lat_work_reg;
        lon_work_next       = lon_work_reg;
        south_next          = south_reg;
        west_next           = west_reg;
        held_lat_next       = held_lat_reg;
        held_lon_next       = held_lon_reg;
        held_speed_next     = held_speed_reg;
        emit                = 1'b0;
        finish              = 1'b0;

        if (!in_sentence_reg) begin
            if (header_pos_reg == 3'd0) begin
                if (rx_byte == nmea_rmc_pkg::CHAR_DOLLAR) begin
                    header_pos_next = 3'd1;
                end
            end else if (rx_byte == nmea_rmc_pkg::hdr_char(header_pos_reg - 3'd1)) begin
                if (header_pos_reg == 3'(nmea_rmc_pkg::HDR_LEN)) begin
                    header_pos_next     = 3'd0;
                    in_sentence_next    = 1'b1;
                    field_index_next    = 4'd1;
                    field_nonempty_next = 1'b0;
                    decimal_seen_next   = 1'b0;
                    number_stopped_next = 1'b0;
                    frac_count_next     = '0;
                    field_accum_next    = '0;
                    status_next         = nmea_rmc_pkg::STATUS_NONE;
                    lat_work_next       = '0;
                    lon_work_next       = '0;
                    south_next          = 1'b0;
                    west_next           = 1'b0;
                    held_speed_next     = '0;
                end else begin
                    header_pos_next = header_pos_reg + 3'd1;
                end
            end else begin
                header_pos_next = 3'd0;
            end
        end else if (rx_byte == nmea_rmc_pkg::CHAR_COMMA) begin
            finish = field_nonempty_reg;
        end else begin
            if (field_index_reg == nmea_rmc_pkg::FLD_STATUS) begin
                status_next = (!field_nonempty_reg && rx_byte == nmea_rmc_pkg::CHAR_A)
                              ? nmea_rmc_pkg::STATUS_A : nmea_rmc_pkg::STATUS_OTHER;
            end
            if (field_index_reg == nmea_rmc_pkg::FLD_NS && !field_nonempty_reg &&
                rx_byte == nmea_rmc_pkg::CHAR_S) begin
                south_next = 1'b1;
            end
            if (field_index_reg == nmea_rmc_pkg::FLD_EW && !field_nonempty_reg &&
                rx_byte == nmea_rmc_pkg::CHAR_W) begin
                west_next = 1'b1;
            end
            if (num_field && !number_stopped_reg) begin
                if (is_digit) begin
                    if (!decimal_seen_reg) begin
                        field_accum_next = push_val;
                    end else if (frac_count_reg < FracW'(FRAC_DIGITS)) begin
                        field_accum_next = push_val;
                        frac_count_next  = frac_count_reg + FracW'(1);
                    end
                end else if (rx_byte == nmea_rmc_pkg::CHAR_DOT && !decimal_seen_reg) begin
                    decimal_seen_next = 1'b1;
                end else begin
                    number_stopped_next = 1'b1;
                end
            end
            field_nonempty_next = 1'b1;
            if (rx_byte == nmea_rmc_pkg::CHAR_STAR) begin
                finish           = 1'b1;
                emit             = 1'b1;
                in_sentence_next = 1'b0;
            end
        end

        if (finish) begin
            if (field_index_reg == nmea_rmc_pkg::FLD_LAT) begin
                lat_work_next = (field_val < ProdW'(LatCap)) ? field_val[27:0] : 28'(LatCap);
            end else if (field_index_reg == nmea_rmc_pkg::FLD_LON) begin
                lon_work_next = (field_val < ProdW'(LonCap)) ? field_val[28:0] : 29'(LonCap);
            end else if (field_index_reg == nmea_rmc_pkg::FLD_SPEED) begin
                held_speed_next = (field_val < ProdW'(SpdCap)) ? field_val[23:0] : 24'(SpdCap);
            end
            if (field_index_reg != nmea_rmc_pkg::FLD_LAST) begin
                field_index_next = field_index_reg + 4'd1;
            end
            field_nonempty_next = 1'b0;
            decimal_seen_next   = 1'b0;
            number_stopped_next = 1'b0;
            frac_count_next     = '0;
            field_accum_next    = '0;
        end

        if (emit && status_next == nmea_rmc_pkg::STATUS_A) begin
            held_lat_next = south_next ? -$signed(lat_work_next) : $signed(lat_work_next);
            held_lon_next = west_next ? -$signed(lon_work_next) : $signed(lon_work_next);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            header_pos_reg     <= '0;
            in_sentence_reg    <= 1'b0;
            field_index_reg    <= '0;
            field_nonempty_reg <= 1'b0;
            decimal_seen_reg   <= 1'b0;
            number_stopped_reg <= 1'b0;
            frac_count_reg     <= '0;
            field_accum_reg    <= '0;
            status_reg         <= nmea_rmc_pkg::STATUS_NONE;
            lat_work_reg       <= '0;
            lon_work_reg       <= '0;
            south_reg          <= 1'b0;
            west_reg           <= 1'b0;
            held_lat_reg       <= '0;
            held_lon_reg       <= '0;
            held_speed_reg     <= '0;
            out_valid_reg      <= 1'b0;
        end else begin
            if (accept) begin
                header_pos_reg     <= header_pos_next;
                in_sentence_reg    <= in_sentence_next;
                field_index_reg    <= field_index_next;
                field_nonempty_reg <= field_nonempty_next;
                decimal_seen_reg   <= decimal_seen_next;
                number_stopped_reg <= number_stopped_next;
                frac_count_reg     <= frac_count_next;
                field_accum_reg    <= field_accum_next;
                status_reg         <= status_next;
                lat_work_reg       <= lat_work_next;
                lon_work_reg       <= lon_work_next;
                south_reg          <= south_next;
                west_reg           <= west_next;
                held_lat_reg       <= held_lat_next;
                held_lon_reg       <= held_lon_next;
                held_speed_reg     <= held_speed_next;
            end
            if (accept && emit) begin
                out_valid_reg <= 1'b1;
            end else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && emit) begin
            out_lat_reg   <= held_lat_next;
            out_lon_reg   <= held_lon_next;
            out_speed_reg <= held_speed_next;
            out_fix_reg   <= (status_next == nmea_rmc_pkg::STATUS_A);
        end
    end

    assign out_valid   = out_valid_reg;
    assign latitude    = out_lat_reg;
    assign longitude   = out_lon_reg;
    assign speed_knots = out_speed_reg;
    assign fix_active  = out_fix_reg;

    // header search and sentence body are exclusive
    a_hdr_idle_in_body: assert property (@(posedge clk) disable iff (!rst_n)
        in_sentence_reg |-> header_pos_reg == 3'd0)
        else $error("header match active inside a sentence");

    // inside a sentence the field counter never reads zero
    a_field_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        in_sentence_reg |-> field_index_reg != 4'd0)
        else $error("field index zero inside a sentence");

    // a closing '*' always leaves a result and ends the sentence
    a_star_emits: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && in_sentence_reg && rx_byte == nmea_rmc_pkg::CHAR_STAR)
        |=> out_valid && !in_sentence_reg)
        else $error("sentence end gave no result");

    // a fix is reported only when the held position could have changed
    a_fix_needs_status: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && emit && status_next != nmea_rmc_pkg::STATUS_A) |=> !fix_active)
        else $error("fix reported without exact status A");

endmodule

`default_nettype wire
